// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define CHK_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");

// next-cycle implication check
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/chcal_pkg.sv
// types and constants of the channel calibration block
`default_nettype none

package chcal_pkg;

  // input item
  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         channel;
    logic signed [31:0] raw_sample;
    logic [2:0]         phase;
    logic               last_channel;
    logic signed [31:0] gain;
    logic signed [63:0] offset;
    logic signed [63:0] physical_offset;
    logic               calibrate_enable;
    logic               no_adjust;
  } item_t;

  // result item
  typedef struct packed {
    logic [5:0]         out_channel;
    logic signed [63:0] value;
    logic               calibrated;
    logic [1:0]         status;
    logic               end_of_cycle;
  } result_t;

  // command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;

  // phase codes
  localparam logic [2:0] PHASE_STARTUP = 3'd0;
  localparam logic [2:0] PHASE_OFFLINE = 3'd2;
  localparam logic [2:0] PHASE_ONLINE  = 3'd3;

  // result status codes
  localparam logic [1:0] STS_SAMPLE      = 2'd0;
  localparam logic [1:0] STS_ACCEPTED    = 2'd1;
  localparam logic [1:0] STS_REF_ONLINE  = 2'd2;
  localparam logic [1:0] STS_REF_COMPOFF = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_COMP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CORR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_CYCLES = 2'd2;

  // full scale used by the correction limit
  localparam int FS_W = 31;
  localparam logic [FS_W-1:0] FULL_SCALE = 31'd2147000000;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADD,
    S_EMIT,
    S_RD,
    S_W_RD,
    S_W_CHK,
    S_W_DIV,
    S_W_SUB,
    S_W_MUL,
    S_W_CMP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_in;
    logic rd_walk;
    logic load_wr;
    logic mul;
    logic add;
    logic div_start;
    logic div_step;
    logic walk_sub;
    logic walk_mul;
    logic walk_wr;
    logic walk_next;
    logic walk_finish;
    logic out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       skip;
    logic       walk_need;
    logic       walk_skip;
    logic       walk_last;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/channel_calibration_auto_offset.sv
// Per-channel gain/offset calibration with automatic offset compensation.
// Input channel item/item_valid/item_stall carries load, sample and
// calibration-request commands; results leave on result/result_valid/
// result_stall. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) the user must use only while the block is idle (not enforced).
// One item is worked at a time. A sample passes the accept, multiply, add
// and emit states to the result register; a load passes accept and load,
// a request accept and emit, a dropped startup sample or an unused command
// accept only. The first offline sample after startup accumulation runs
// the offset walk between its accept and multiply states: a skipped channel
// passes read and check, an adjusted one also divide (64-step bit-serial
// divider), subtract, multiply, compare; the sample's channel is reread.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the result, and the block stalls its input once
// a second result is ready. Synchronous reset clears the control state,
// the channel loaded bits and accumulator valid bits, and the registers
// (compensation off, limit 0, cycle count 1); no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module channel_calibration_auto_offset #(
  parameter int CHANNELS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [chcal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [chcal_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire chcal_pkg::item_t                item,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output chcal_pkg::result_t                   result
);

  localparam int DEPTH = (CHANNELS < 64) ? CHANNELS : 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  chcal_pkg::ctl_t ctl;
  chcal_pkg::sts_t sts;

  // controller
  chcal_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  // datapath
  chcal_dp #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .ctl          (ctl),
    .sts          (sts)
  );

  // a stalled result stays offered
  `CHK_NEXT(a_out_hold, clk, rst, result_valid && result_stall, result_valid)
  // a result only enters a free output register
  `CHK_IMPL(a_out_free, clk, rst, ctl.out_load, !result_valid || !result_stall)
  // table writes never collide
  `CHK_IMPL(a_wr_excl, clk, rst, ctl.load_wr, !ctl.walk_wr && !ctl.add)

endmodule

`default_nettype wire

// File: rtl/chcal_ctrl.sv
// controller state machine of the channel calibration block
`default_nettype none

module chcal_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire chcal_pkg::sts_t sts,
  output chcal_pkg::ctl_t      ctl
);

  chcal_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chcal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      chcal_pkg::S_IDLE: begin
        if (item_valid) begin
          unique case (sts.command)
            chcal_pkg::CMD_LOAD:    state_next = chcal_pkg::S_LOAD;
            chcal_pkg::CMD_REQUEST: state_next = chcal_pkg::S_EMIT;
            chcal_pkg::CMD_SAMPLE: begin
              if (sts.skip) begin
                state_next = chcal_pkg::S_IDLE;
              end else if (sts.walk_need) begin
                state_next = chcal_pkg::S_W_RD;
              end else begin
                state_next = chcal_pkg::S_MUL;
              end
            end
            default: state_next = chcal_pkg::S_IDLE;
          endcase
        end
      end
      chcal_pkg::S_LOAD: state_next = chcal_pkg::S_IDLE;
      chcal_pkg::S_MUL:  state_next = chcal_pkg::S_ADD;
      chcal_pkg::S_ADD:  state_next = chcal_pkg::S_EMIT;
      chcal_pkg::S_EMIT: begin
        if (sts.out_free) state_next = chcal_pkg::S_IDLE;
      end
      chcal_pkg::S_RD:   state_next = chcal_pkg::S_MUL;
      chcal_pkg::S_W_RD: state_next = chcal_pkg::S_W_CHK;
      chcal_pkg::S_W_CHK: begin
        if (!sts.walk_skip) begin
          state_next = chcal_pkg::S_W_DIV;
        end else if (sts.walk_last) begin
          state_next = chcal_pkg::S_RD;
        end else begin
          state_next = chcal_pkg::S_W_RD;
        end
      end
      chcal_pkg::S_W_DIV: begin
        if (sts.div_last) state_next = chcal_pkg::S_W_SUB;
      end
      chcal_pkg::S_W_SUB: state_next = chcal_pkg::S_W_MUL;
      chcal_pkg::S_W_MUL: state_next = chcal_pkg::S_W_CMP;
      chcal_pkg::S_W_CMP: begin
        state_next = sts.walk_last ? chcal_pkg::S_RD : chcal_pkg::S_W_RD;
      end
      default: state_next = chcal_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    item_stall = 1'b1;
    unique case (state)
      chcal_pkg::S_IDLE: begin
        item_stall = 1'b0;
        ctl.rd_in  = 1'b1;
        ctl.accept = item_valid;
      end
      chcal_pkg::S_LOAD: ctl.load_wr = 1'b1;
      chcal_pkg::S_MUL:  ctl.mul = 1'b1;
      chcal_pkg::S_ADD:  ctl.add = 1'b1;
      chcal_pkg::S_EMIT: ctl.out_load = sts.out_free;
      chcal_pkg::S_RD:   ctl.rd_walk = 1'b0;
      chcal_pkg::S_W_RD: ctl.rd_walk = 1'b1;
      chcal_pkg::S_W_CHK: begin
        ctl.rd_walk     = 1'b1;
        ctl.div_start   = !sts.walk_skip;
        ctl.walk_next   = sts.walk_skip && !sts.walk_last;
        ctl.walk_finish = sts.walk_skip && sts.walk_last;
      end
      chcal_pkg::S_W_DIV: begin
        ctl.rd_walk  = 1'b1;
        ctl.div_step = 1'b1;
      end
      chcal_pkg::S_W_SUB: begin
        ctl.rd_walk  = 1'b1;
        ctl.walk_sub = 1'b1;
      end
      chcal_pkg::S_W_MUL: begin
        ctl.rd_walk  = 1'b1;
        ctl.walk_mul = 1'b1;
      end
      chcal_pkg::S_W_CMP: begin
        ctl.rd_walk     = 1'b1;
        ctl.walk_wr     = 1'b1;
        ctl.walk_next   = !sts.walk_last;
        ctl.walk_finish = sts.walk_last;
      end
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/chcal_dp.sv
// datapath of the channel calibration block: tables, multiplier, divider
`default_nettype none

module chcal_dp #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [chcal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [chcal_pkg::CFG_W-1:0]        cfg_data,
  input  wire chcal_pkg::item_t                   item,
  input  wire logic                               result_stall,
  output logic                                    result_valid,
  output chcal_pkg::result_t                      result,
  input  wire chcal_pkg::ctl_t                    ctl,
  output chcal_pkg::sts_t                         sts
);

  // per-channel coefficient record
  typedef struct packed {
    logic signed [31:0] gain;
    logic signed [63:0] orig;
    logic signed [63:0] phys;
    logic               en;
    logic               noadj;
  } coef_t;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // configuration registers
  logic        auto_comp;
  logic [15:0] max_corr;
  logic [15:0] comp_cycles;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_comp   <= 1'b0;
      max_corr    <= '0;
      comp_cycles <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chcal_pkg::REG_AUTO_COMP:   auto_comp   <= cfg_data[0];
        chcal_pkg::REG_MAX_CORR:    max_corr    <= cfg_data;
        chcal_pkg::REG_COMP_CYCLES: comp_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing state
  chcal_pkg::item_t item_q;
  logic             ch_ok_q;
  logic             eff0_q;
  logic [2:0]       last_phase;
  logic             pending;
  logic             check_pending;
  logic [15:0]      count;
  logic [IDX_W-1:0] walk_idx;
  chcal_pkg::result_t res;

  logic ch_ok_in;
  logic eff_zero;
  logic eff_off;
  assign ch_ok_in = int'(item.channel) < DEPTH;
  assign eff_zero = pending || (item.phase == chcal_pkg::PHASE_STARTUP);
  assign eff_off  = !pending && (item.phase == chcal_pkg::PHASE_OFFLINE);

  // memory read address
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_ch;
  assign wr_ch = item_q.channel[IDX_W-1:0];
  always_comb begin
    if (ctl.rd_in) begin
      rd_addr = item.channel[IDX_W-1:0];
    end else if (ctl.rd_walk) begin
      rd_addr = walk_idx;
    end else begin
      rd_addr = wr_ch;
    end
  end

  // coefficient memory with loaded bits
  coef_t            coef_mem [DEPTH];
  coef_t            coef_q;
  logic [DEPTH-1:0] loaded;
  logic             loaded_q;

  always_ff @(posedge clk) begin
    if (ctl.load_wr && ch_ok_q) begin
      coef_mem[wr_ch] <= '{gain: item_q.gain, orig: item_q.offset,
                           phys: item_q.physical_offset,
                           en: item_q.calibrate_enable, noadj: item_q.no_adjust};
    end
    coef_q <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      loaded_q <= 1'b0;
    end else begin
      if (ctl.load_wr && ch_ok_q) loaded[wr_ch] <= 1'b1;
      loaded_q <= loaded[rd_addr];
    end
  end

  // offset memory, written by loads and by the walk
  logic signed [63:0] offset_mem [DEPTH];
  logic signed [63:0] offset_q;
  logic signed [63:0] walk_val;

  always_ff @(posedge clk) begin
    if (ctl.load_wr && ch_ok_q) begin
      offset_mem[wr_ch] <= item_q.offset;
    end else if (ctl.walk_wr) begin
      offset_mem[walk_idx] <= walk_val;
    end
    offset_q <= offset_mem[rd_addr];
  end

  // accumulator memory with valid bits
  logic signed [63:0] acc_mem [DEPTH];
  logic signed [63:0] acc_q;
  logic [DEPTH-1:0]   acc_vld;
  logic               acc_vq;
  logic signed [63:0] acc_cur;
  logic signed [63:0] acc_new;
  logic               acc_wr;
  logic               use_cal;
  logic signed [63:0] prod;

  assign acc_cur = acc_vq ? acc_q : '0;
  assign acc_new = sat_add(acc_cur, prod);
  assign acc_wr  = ctl.add && use_cal && eff0_q;

  always_ff @(posedge clk) begin
    if (acc_wr) acc_mem[wr_ch] <= acc_new;
    acc_q <= acc_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
      acc_vq  <= 1'b0;
    end else begin
      if (ctl.walk_finish) begin
        acc_vld <= '0;
      end else if (acc_wr) begin
        acc_vld[wr_ch] <= 1'b1;
      end
      acc_vq <= acc_vld[rd_addr];
    end
  end

  // sample conversion
  logic en_q;
  logic signed [63:0] conv_val;
  assign en_q     = loaded_q && coef_q.en;
  assign conv_val = use_cal ? sat_add(prod, offset_q) : 64'(item_q.raw_sample);

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod    <= 64'(item_q.raw_sample) * 64'(coef_q.gain);
      use_cal <= ch_ok_q && en_q;
    end
  end

  // request status from the last sample phase and the enable
  logic [1:0] req_status;
  always_comb begin
    if (last_phase == chcal_pkg::PHASE_ONLINE) begin
      req_status = chcal_pkg::STS_REF_ONLINE;
    end else if (auto_comp) begin
      req_status = chcal_pkg::STS_ACCEPTED;
    end else begin
      req_status = chcal_pkg::STS_REF_COMPOFF;
    end
  end

  // item latch, result staging, startup bookkeeping
  logic [15:0] count_inc;
  assign count_inc = (count != 16'hFFFF) ? count + 16'd1 : count;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_q  <= item;
      ch_ok_q <= ch_ok_in;
      eff0_q  <= eff_zero;
    end
    if (ctl.accept && item.command == chcal_pkg::CMD_REQUEST) begin
      res <= '{out_channel: '0, value: '0, calibrated: 1'b0,
               status: req_status, end_of_cycle: 1'b0};
    end else if (ctl.add) begin
      res <= '{out_channel: item_q.channel, value: conv_val, calibrated: use_cal,
               status: chcal_pkg::STS_SAMPLE, end_of_cycle: item_q.last_channel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase    <= chcal_pkg::PHASE_STARTUP;
      pending       <= 1'b0;
      check_pending <= 1'b0;
      count         <= '0;
    end else begin
      if (ctl.accept && item.command == chcal_pkg::CMD_SAMPLE) begin
        last_phase <= item.phase;
      end
      if (ctl.accept && item.command == chcal_pkg::CMD_REQUEST &&
          last_phase != chcal_pkg::PHASE_ONLINE && auto_comp) begin
        pending <= 1'b1;
      end
      if (ctl.add && eff0_q) begin
        check_pending <= 1'b1;
        if (item_q.last_channel) begin
          count <= count_inc;
          if (count_inc == comp_cycles) pending <= 1'b0;
        end
      end
      if (ctl.walk_finish) begin
        count         <= '0;
        check_pending <= 1'b0;
      end
    end
  end

  // walk channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
    end else if (ctl.walk_finish) begin
      walk_idx <= '0;
    end else if (ctl.walk_next) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
  end

  // restoring divider: one quotient bit per cycle
  logic [63:0] div_q;
  logic [15:0] div_rem;
  logic [5:0]  div_cnt;
  logic        div_neg;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic signed [63:0] avg;

  assign rem_sh = {div_rem, div_q[63]};
  assign rem_ge = rem_sh >= {1'b0, count};
  assign avg    = div_neg ? -$signed(div_q) : $signed(div_q);

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      div_q   <= acc_cur[63] ? 64'(-acc_cur) : 64'(acc_cur);
      div_rem <= '0;
      div_cnt <= '0;
      div_neg <= acc_cur[63];
    end else if (ctl.div_step) begin
      div_rem <= rem_ge ? 16'(rem_sh - {1'b0, count}) : rem_sh[15:0];
      div_q   <= {div_q[62:0], rem_ge};
      div_cnt <= div_cnt + 6'd1;
    end
  end

  // new offset and correction limit
  logic signed [63:0] now_r;
  logic [47:0]        lim1;
  logic [63:0]        diff_r;
  logic [54:0]        p_lo;
  logic [54:0]        p_hi;
  logic [31:0]        gain_abs;
  logic signed [64:0] diff_s;
  logic [79:0]        lhs;
  logic [79:0]        rhs;
  logic               too_large;

  assign gain_abs  = coef_q.gain[31] ? 32'(-coef_q.gain) : 32'(coef_q.gain);
  assign diff_s    = {now_r[63], now_r} - {coef_q.orig[63], coef_q.orig};
  assign lhs       = {diff_r, 16'd0};
  assign rhs       = {1'b0, p_hi, 24'd0} + 80'(p_lo);
  assign too_large = lhs > rhs;
  assign walk_val  = too_large ? coef_q.orig : now_r;

  always_ff @(posedge clk) begin
    if (ctl.walk_sub) begin
      now_r <= sat_sub(coef_q.phys, avg);
      lim1  <= 48'(max_corr) * 48'(gain_abs);
    end
    if (ctl.walk_mul) begin
      diff_r <= diff_s[64] ? 64'(-diff_s) : diff_s[63:0];
      p_lo   <= 55'(lim1[23:0]) * 55'(chcal_pkg::FULL_SCALE);
      p_hi   <= 55'(lim1[47:24]) * 55'(chcal_pkg::FULL_SCALE);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) result <= res;
  end

  // status to controller
  always_comb begin
    sts.command   = item.command;
    sts.skip      = eff_zero && !auto_comp;
    sts.walk_need = eff_off && check_pending;
    sts.walk_skip = !en_q || coef_q.noadj || (count == 16'd0);
    sts.walk_last = walk_idx == IDX_W'(DEPTH - 1);
    sts.div_last  = div_cnt == 6'd63;
    sts.out_free  = !result_valid || !result_stall;
  end

endmodule

`default_nettype wire

// File: tb/sv/channel_calibration_auto_offset_tb.sv
// testbench of the channel calibration block with automatic offset compensation
`default_nettype none

module channel_calibration_auto_offset_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NCH          = 64;
  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam logic [2:0]  PHASE_PREPULSE  = 3'd1;
  localparam logic [2:0]  PHASE_POSTPULSE = 3'd4;
  localparam logic [31:0] FULL_RANGE   = 32'd2147000000;
  localparam logic signed [31:0] GAIN_ONE = 32'sd16777216;
  localparam longint      LMAX = 64'sh7fffffffffffffff;
  localparam longint      LMIN = 64'sh8000000000000000;
  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          SETTLE_CYCLES  = 16;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  logic [chcal_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [chcal_pkg::CFG_W-1:0]     cfg_data = '0;
  logic    item_valid = 1'b0;
  logic    item_stall;
  chcal_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  chcal_pkg::result_t result;

  channel_calibration_auto_offset u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #2 clk = ~clk;

  // predictor copy of the block state
  logic signed [31:0] gain_tab [NCH];
  longint             offset_tab [NCH];
  longint             orig_offset_tab [NCH];
  longint             phys_offset_tab [NCH];
  longint             sum_tab [NCH];
  bit                 cal_on [NCH];
  bit                 hold_offset [NCH];
  int unsigned        cycle_count;
  bit                 request_open;
  bit                 walk_due;
  logic [2:0]         prev_phase;
  bit                 comp_on;
  logic [15:0]        corr_limit;
  logic [15:0]        cycle_target;

  chcal_pkg::result_t expected_results [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;

  typedef struct {
    chcal_pkg::item_t   it;
    bit                 typed;
    chcal_pkg::result_t res;
  } row_t;

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? LMIN : LMAX;
    return s[63:0];
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? LMIN : LMAX;
    return s[63:0];
  endfunction

  // offset change beyond max_correction * |gain| * full range, exact
  function automatic bit change_over_limit(longint now_v, longint orig_v,
                                           logic signed [31:0] g);
    logic [63:0]  d;
    logic [32:0]  mag;
    logic [127:0] lhs, rhs;
    d   = (now_v >= orig_v) ? 64'(now_v - orig_v) : 64'(orig_v - now_v);
    mag = g[31] ? 33'(-{g[31], g}) : {1'b0, g};
    lhs = {64'd0, d} << 16;
    rhs = 128'(corr_limit) * 128'(mag) * 128'(FULL_RANGE);
    return lhs > rhs;
  endfunction

  task automatic reset_model();
    for (int c = 0; c < NCH; c++) begin
      gain_tab[c] = GAIN_ONE;
      offset_tab[c] = 0;
      orig_offset_tab[c] = 0;
      phys_offset_tab[c] = 0;
      sum_tab[c] = 0;
      cal_on[c] = 0;
      hold_offset[c] = 0;
    end
    cycle_count = 0;
    request_open = 0;
    walk_due = 0;
    prev_phase = chcal_pkg::PHASE_STARTUP;
    comp_on = 0;
    corr_limit = 0;
    cycle_target = 1;
  endtask

  // re-centre each adjustable channel on its physical offset
  task automatic auto_zero_walk();
    longint avg, nv;
    for (int c = 0; c < NCH; c++) begin
      if (!cal_on[c] || cycle_count == 0 || hold_offset[c]) continue;
      avg = sum_tab[c] / longint'(cycle_count);
      nv = sub_sat(phys_offset_tab[c], avg);
      if (change_over_limit(nv, orig_offset_tab[c], gain_tab[c]))
        nv = orig_offset_tab[c];
      offset_tab[c] = nv;
    end
    cycle_count = 0;
    walk_due = 0;
    for (int c = 0; c < NCH; c++) sum_tab[c] = 0;
  endtask

  // apply one item to the predicted state; returns 1 with a result
  task automatic predict_item(input chcal_pkg::item_t it, output bit has_res,
                              output chcal_pkg::result_t r);
    logic [2:0] eff;
    longint prod;
    r = '0;
    has_res = 0;
    unique case (it.command)
      chcal_pkg::CMD_LOAD: begin
        gain_tab[it.channel] = it.gain;
        offset_tab[it.channel] = it.offset;
        orig_offset_tab[it.channel] = it.offset;
        phys_offset_tab[it.channel] = it.physical_offset;
        cal_on[it.channel] = it.calibrate_enable;
        hold_offset[it.channel] = it.no_adjust;
      end
      chcal_pkg::CMD_REQUEST: begin
        has_res = 1;
        if (prev_phase == chcal_pkg::PHASE_ONLINE) r.status = chcal_pkg::STS_REF_ONLINE;
        else if (comp_on) begin
          request_open = 1;
          r.status = chcal_pkg::STS_ACCEPTED;
        end else r.status = chcal_pkg::STS_REF_COMPOFF;
      end
      chcal_pkg::CMD_SAMPLE: begin
        prev_phase = it.phase;
        eff = request_open ? chcal_pkg::PHASE_STARTUP : it.phase;
        if (!(eff == chcal_pkg::PHASE_STARTUP && !comp_on)) begin
          if (eff == chcal_pkg::PHASE_OFFLINE && walk_due) auto_zero_walk();
          has_res = 1;
          r.out_channel = it.channel;
          r.value = longint'(it.raw_sample);
          r.status = chcal_pkg::STS_SAMPLE;
          r.end_of_cycle = it.last_channel;
          if (cal_on[it.channel]) begin
            prod = longint'(it.raw_sample) * longint'(gain_tab[it.channel]);
            r.value = add_sat(prod, offset_tab[it.channel]);
            r.calibrated = 1;
            if (eff == chcal_pkg::PHASE_STARTUP)
              sum_tab[it.channel] = add_sat(sum_tab[it.channel], prod);
          end
          if (eff == chcal_pkg::PHASE_STARTUP) begin
            walk_due = 1;
            if (it.last_channel) begin
              if (cycle_count < 32'hffff) cycle_count++;
              if (cycle_count == 32'(cycle_target)) request_open = 0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    errors++;
  endtask

  // result side: compare and stall at random
  always @(posedge clk) begin
    chcal_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) report("unexpected item", result.value, 64'd0);
      else begin
        want = expected_results.pop_front();
        if (result.out_channel != want.out_channel)
          report("out_channel", 64'(result.out_channel), 64'(want.out_channel));
        if (result.value != want.value) report("value", result.value, want.value);
        if (result.calibrated != want.calibrated)
          report("calibrated", 64'(result.calibrated), 64'(want.calibrated));
        if (result.status != want.status)
          report("status", 64'(result.status), 64'(want.status));
        if (result.end_of_cycle != want.end_of_cycle)
          report("end_of_cycle", 64'(result.end_of_cycle), 64'(want.end_of_cycle));
      end
    end
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any accepted item or taken result
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // send one item; an explicit expectation overrides the prediction
  task automatic send(input chcal_pkg::item_t it, input bit typed,
                      input chcal_pkg::result_t res);
    bit has;
    chcal_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(it, has, r);
    if (typed) expected_results.push_back(res);
    else if (has) expected_results.push_back(r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [chcal_pkg::CFG_IDX_W-1:0] idx,
                           logic [chcal_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      chcal_pkg::REG_AUTO_COMP:   comp_on = val[0];
      chcal_pkg::REG_MAX_CORR:    corr_limit = val;
      chcal_pkg::REG_COMP_CYCLES: cycle_target = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(bit comp, logic [15:0] corr, logic [15:0] cycles);
    write_reg(chcal_pkg::REG_AUTO_COMP, {15'd0, comp});
    write_reg(chcal_pkg::REG_MAX_CORR, corr);
    write_reg(chcal_pkg::REG_COMP_CYCLES, cycles);
  endtask

  function automatic chcal_pkg::item_t sample(logic [5:0] ch, logic signed [31:0] raw,
                                              logic [2:0] ph, bit last);
    chcal_pkg::item_t it;
    it = '0;
    it.command = chcal_pkg::CMD_SAMPLE;
    it.channel = ch;
    it.raw_sample = raw;
    it.phase = ph;
    it.last_channel = last;
    return it;
  endfunction

  function automatic chcal_pkg::item_t load(logic [5:0] ch, logic signed [31:0] g,
                                            longint off, longint phys, bit en, bit hold);
    chcal_pkg::item_t it;
    it = '0;
    it.command = chcal_pkg::CMD_LOAD;
    it.channel = ch;
    it.gain = g;
    it.offset = off;
    it.physical_offset = phys;
    it.calibrate_enable = en;
    it.no_adjust = hold;
    return it;
  endfunction

  function automatic chcal_pkg::item_t ctrl(logic [1:0] cmd);
    chcal_pkg::item_t it;
    it = '0;
    it.command = cmd;
    return it;
  endfunction

  function automatic row_t checked(chcal_pkg::item_t it);
    row_t r;
    r.it = it;
    r.typed = 0;
    r.res = '0;
    return r;
  endfunction

  function automatic row_t typed_row(chcal_pkg::item_t it, chcal_pkg::result_t res);
    row_t r;
    r.it = it;
    r.typed = 1;
    r.res = res;
    return r;
  endfunction

  function automatic chcal_pkg::result_t status_only(logic [1:0] st);
    chcal_pkg::result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // random item, biased toward the low eight channels and the startup, offline and online phases
  function automatic chcal_pkg::item_t random_item();
    chcal_pkg::item_t it;
    logic [223:0] noise;
    int pick;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
    it = noise[$bits(chcal_pkg::item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 18) it.command = chcal_pkg::CMD_LOAD;
    else if (pick < 88) it.command = chcal_pkg::CMD_SAMPLE;
    else if (pick < 97) it.command = chcal_pkg::CMD_REQUEST;
    else it.command = CMD_RESERVED;
    if ($urandom_range(4) != 0) it.channel = 6'($urandom_range(7));
    pick = $urandom_range(9);
    if (pick < 4) it.raw_sample = 32'($signed($urandom_range(4000)) - 2000);
    else if (pick == 4) it.raw_sample = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    pick = $urandom_range(9);
    if (pick < 4) it.phase = chcal_pkg::PHASE_STARTUP;
    else if (pick < 6) it.phase = chcal_pkg::PHASE_OFFLINE;
    else if (pick < 8) it.phase = chcal_pkg::PHASE_ONLINE;
    else if (pick == 8) it.phase = $urandom_range(1) ? PHASE_PREPULSE : PHASE_POSTPULSE;
    it.last_channel = ($urandom_range(3) == 0);
    if ($urandom_range(2) != 0) begin
      it.gain = GAIN_ONE + $signed(32'($urandom_range(2000000))) - 32'sd1000000;
      it.offset = longint'($urandom_range(20000000)) - 64'sd10000000;
      it.physical_offset = longint'($urandom_range(20000000)) - 64'sd10000000;
    end
    it.calibrate_enable = ($urandom_range(3) != 0);
    it.no_adjust = ($urandom_range(4) == 0);
    return it;
  endfunction

  row_t rows [$];

  initial begin
    chcal_pkg::result_t r0;
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, compensation off
    r0 = '0;
    r0.value = 5;
    rows.push_back(typed_row(sample(0, 5, chcal_pkg::PHASE_ONLINE, 0), r0));
    rows.push_back(typed_row(ctrl(chcal_pkg::CMD_REQUEST),
                             status_only(chcal_pkg::STS_REF_ONLINE)));
    rows.push_back(checked(sample(63, 32'sh80000000, chcal_pkg::PHASE_OFFLINE, 1)));
    rows.push_back(typed_row(ctrl(chcal_pkg::CMD_REQUEST),
                             status_only(chcal_pkg::STS_REF_COMPOFF)));
    rows.push_back(checked(ctrl(CMD_RESERVED)));
    rows.push_back(checked(sample(1, 7, chcal_pkg::PHASE_STARTUP, 1)));
    rows.push_back(checked(load(1, 32'sh7fffffff, LMAX, LMAX, 1, 1)));
    rows.push_back(checked(sample(1, 32'sh7fffffff, chcal_pkg::PHASE_ONLINE, 1)));
    rows.push_back(checked(load(2, 32'sh80000000, LMIN, LMIN, 1, 0)));
    rows.push_back(checked(sample(2, 32'sh7fffffff, PHASE_POSTPULSE, 0)));
    rows.push_back(checked(sample(2, 32'sh80000000, 3'd7, 1)));
    rows.push_back(checked(sample(1, -3, 3'd5, 0)));
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
    drain();

    // directed, auto-zero with request, skipped and zero-gain channels
    set_regs(1, 16'hffff, 2);
    rows.delete();
    rows.push_back(checked(load(3, GAIN_ONE, 0, 64'sd1000000, 1, 0)));
    rows.push_back(checked(load(4, GAIN_ONE, 5, 64'sd999, 1, 1)));
    rows.push_back(checked(load(5, 0, 9, 64'sd12345, 1, 0)));
    rows.push_back(typed_row(ctrl(chcal_pkg::CMD_REQUEST),
                             status_only(chcal_pkg::STS_ACCEPTED)));
    rows.push_back(checked(sample(3, 100, PHASE_PREPULSE, 0)));
    rows.push_back(checked(sample(5, 100, PHASE_PREPULSE, 1)));
    rows.push_back(checked(sample(3, 300, PHASE_PREPULSE, 1)));
    rows.push_back(checked(sample(3, 1, chcal_pkg::PHASE_OFFLINE, 0)));
    rows.push_back(checked(sample(4, 1, chcal_pkg::PHASE_OFFLINE, 1)));
    rows.push_back(checked(sample(5, 1, chcal_pkg::PHASE_ONLINE, 1)));
    foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
    drain();

    // random phases under three idle patterns and several register settings
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 9 : (m == 1) ? 73 : 0;
      stall_pct     = (m == 0) ? 73 : (m == 1) ? 9 : 0;
      for (int k = 0; k < 2; k++) begin
        case (m * 2 + k)
          0: set_regs(1, 16'd0, 16'd1);
          1: set_regs(1, 16'hffff, 16'hffff);
          2: set_regs(0, 16'($urandom()), 16'($urandom_range(1, 4)));
          3: set_regs(1, 16'($urandom_range(1, 40)), 16'd0);
          4: set_regs(1, 16'($urandom()), 16'($urandom_range(1, 6)));
          default: set_regs(1, 16'($urandom_range(1, 8)), 16'd3);
        endcase
        repeat (66) send(random_item(), 0, '0);
        drain();
      end
    end

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
